[hdl/md5_pkg.sv]
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and step tables of the MD5 digest core.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 4;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    // One block word handed from the front to the back.
    typedef struct packed {
        logic [31:0] word;
        logic        digest;    // last word of the closing block
    } md5_word_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MARK,
        FS_PAD,
        FS_LEN_HI
    } md5_front_state_t;

    typedef enum logic [1:0] {
        BS_LOAD,
        BS_ROUND,
        BS_ADD,
        BS_OUT
    } md5_back_state_t;

    localparam logic [31:0] SINE_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

endpackage

`default_nettype wire

[hdl/md5_fifo.sv]
// ----------------------------------------------------------------------------
// md5_fifo
// Short word queue between the front and the back of the digest core.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_fifo
    import md5_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  md5_word_t      push_data,
    output logic           full,
    input  wire logic      pop,
    output md5_word_t      pop_data,
    output logic           empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    md5_word_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("push into a full queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C) else $error("queue count out of range");
    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push && count_reg == 1) |=> empty)
        else $error("queue not empty after last pop");

endmodule

`default_nettype wire

[hdl/md5_front.sv]
// ----------------------------------------------------------------------------
// md5_front
// Takes message requests, packs bytes into block words and appends padding
// and the bit length on the final request.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_front
    import md5_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] message_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic        final_item,
    output logic             push,
    output md5_word_t        push_data,
    input  wire logic        full
);

    md5_front_state_t state_reg, state_next;
    logic [3:0]  wcnt_reg;
    logic [60:0] total_reg, total_next;
    logic [2:0]  count_eff;
    logic [31:0] packed_word;
    logic [63:0] bit_len;
    logic        accept;

    assign count_eff = !final_item ? 3'd4 : ((byte_count > 3'd4) ? 3'd4 : byte_count);
    assign accept    = in_valid && in_ready;
    assign bit_len   = {total_reg, 3'b000};

    // Keep the valid bytes; on a short final word the mark goes in place.
    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (3'(b) < count_eff)
            begin
                packed_word[8*b +: 8] = message_word[8*b +: 8];
            end
            else if (3'(b) == count_eff)
            begin
                packed_word[8*b +: 8] = PAD_MARK;
            end
            else
            begin
                packed_word[8*b +: 8] = 8'h00;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        in_ready         = 1'b0;
        push             = 1'b0;
        push_data.word   = 32'h0;
        push_data.digest = 1'b0;
        total_next       = total_reg;
        case (state_reg)
            FS_IDLE:
            begin
                in_ready       = !full;
                push           = accept;
                push_data.word = packed_word;
                if (accept)
                begin
                    total_next = total_reg + 61'(count_eff);
                    if (final_item)
                    begin
                        state_next = (count_eff == 3'd4) ? FS_MARK : FS_PAD;
                    end
                end
            end
            FS_MARK:
            begin
                push           = !full;
                push_data.word = {24'h0, PAD_MARK};
                if (!full)
                begin
                    state_next = FS_PAD;
                end
            end
            FS_PAD:
            begin
                push = !full;
                if (wcnt_reg == 4'd14)
                begin
                    push_data.word = bit_len[31:0];
                    if (!full)
                    begin
                        state_next = FS_LEN_HI;
                    end
                end
            end
            FS_LEN_HI:
            begin
                push             = !full;
                push_data.word   = bit_len[63:32];
                push_data.digest = 1'b1;
                if (!full)
                begin
                    total_next = '0;
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
            if (push)
            begin
                wcnt_reg <= wcnt_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/md5_back.sv]
// ----------------------------------------------------------------------------
// md5_back
// Loads 16 words, runs the 64 MD5 steps one per cycle, folds the result into
// the chaining value and sends out the digest after the closing block.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_back
    import md5_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    output logic        pop,
    input  md5_word_t   pop_data,
    input  wire logic   empty,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [31:0] digest_word,
    output logic [1:0]  word_number,
    output logic        digest_done
);

    md5_back_state_t state_reg, state_next;
    logic [31:0] blk_reg [16];
    logic [31:0] cv_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [3:0]  ld_cnt_reg;
    logic [5:0]  round_reg;
    logic [1:0]  wn_reg;
    logic        digest_pend_reg;

    logic [1:0]  stage;
    logic [3:0]  idx;
    logic [31:0] fn, sum;
    logic [63:0] dbl;
    logic [31:0] b_new;

    assign stage = round_reg[5:4];

    always_comb
    begin
        case (stage)
            2'd0:
            begin
                fn  = (b_reg & c_reg) | (~b_reg & d_reg);
                idx = round_reg[3:0];
            end
            2'd1:
            begin
                fn  = (d_reg & b_reg) | (~d_reg & c_reg);
                idx = 4'(round_reg[3:0] * 4'd5 + 4'd1);
            end
            2'd2:
            begin
                fn  = b_reg ^ c_reg ^ d_reg;
                idx = 4'(round_reg[3:0] * 4'd3 + 4'd5);
            end
            default:
            begin
                fn  = c_reg ^ (b_reg | ~d_reg);
                idx = 4'(round_reg[3:0] * 4'd7);
            end
        endcase
        sum   = a_reg + fn + SINE_TABLE[round_reg] + blk_reg[idx];
        dbl   = {sum, sum} << ROT_TABLE[{stage, round_reg[1:0]}];
        b_new = b_reg + dbl[63:32];
    end

    assign out_valid   = (state_reg == BS_OUT);
    assign digest_word = cv_reg[wn_reg];
    assign word_number = wn_reg;
    assign digest_done = (wn_reg == 2'd3);

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            BS_LOAD:
            begin
                pop = !empty;
                if (!empty && ld_cnt_reg == 4'd15)
                begin
                    state_next = BS_ROUND;
                end
            end
            BS_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = BS_ADD;
                end
            end
            BS_ADD:
            begin
                state_next = digest_pend_reg ? BS_OUT : BS_LOAD;
            end
            BS_OUT:
            begin
                if (out_ready && wn_reg == 2'd3)
                begin
                    state_next = BS_LOAD;
                end
            end
            default:
            begin
                state_next = BS_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            blk_reg[ld_cnt_reg] <= pop_data.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg          <= '{IV_A, IV_B, IV_C, IV_D};
            a_reg           <= '0;
            b_reg           <= '0;
            c_reg           <= '0;
            d_reg           <= '0;
            ld_cnt_reg      <= '0;
            round_reg       <= '0;
            wn_reg          <= '0;
            digest_pend_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                BS_LOAD:
                begin
                    if (pop)
                    begin
                        ld_cnt_reg <= ld_cnt_reg + 1'b1;
                        if (ld_cnt_reg == 4'd15)
                        begin
                            digest_pend_reg <= pop_data.digest;
                            a_reg     <= cv_reg[0];
                            b_reg     <= cv_reg[1];
                            c_reg     <= cv_reg[2];
                            d_reg     <= cv_reg[3];
                            round_reg <= '0;
                        end
                    end
                end
                BS_ROUND:
                begin
                    a_reg     <= d_reg;
                    b_reg     <= b_new;
                    c_reg     <= b_reg;
                    d_reg     <= c_reg;
                    round_reg <= round_reg + 1'b1;
                end
                BS_ADD:
                begin
                    cv_reg[0] <= cv_reg[0] + a_reg;
                    cv_reg[1] <= cv_reg[1] + b_reg;
                    cv_reg[2] <= cv_reg[2] + c_reg;
                    cv_reg[3] <= cv_reg[3] + d_reg;
                    wn_reg    <= '0;
                end
                BS_OUT:
                begin
                    if (out_ready)
                    begin
                        wn_reg <= wn_reg + 1'b1;
                        // Start the next message from the initial words.
                        if (wn_reg == 2'd3)
                        begin
                            cv_reg <= '{IV_A, IV_B, IV_C, IV_D};
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/md5_message_digest_core.sv]
// ----------------------------------------------------------------------------
// md5_message_digest_core
// Streaming MD5 engine: words in, four digest words out per message.
// ----------------------------------------------------------------------------
// Message words enter on the in_ channel, first byte in bits 7:0; byte_count
// matters only on the final request. The front packs words and appends the
// padding and bit length into a short queue; the back loads 16 words from the
// queue (one a cycle while the queue is not empty), runs the 64 steps one a
// cycle and adds into the chaining value. The back loads no new block words
// until the previous block has been added in and any digest sent. The
// padding and bit length close the message in one or two blocks; after the
// last of them the digest leaves as four requests, lowest word first, with
// digest_done on the last.
`default_nettype none

module md5_message_digest_core
    import md5_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] message_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic        final_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [1:0]       word_number,
    output logic             digest_done
);

    md5_word_t push_data, pop_data;
    logic      push, pop, full, empty;

    md5_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .message_word (message_word),
        .byte_count   (byte_count),
        .final_item   (final_item),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    md5_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    md5_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop         (pop),
        .pop_data    (pop_data),
        .empty       (empty),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_number (word_number),
        .digest_done (digest_done)
    );

endmodule

`default_nettype wire
